// File: hdl/ks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_pkg: shared definitions for the keyed record sorter
// Default sizes, the key width and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ks_pkg;

	localparam int MAX_ITEMS_DEF    = 64;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int KEY_BITS         = 32;

	typedef struct packed {
		logic load;   // insert the incoming record into the chain
		logic shift;  // move every cell one place toward the head
	} ks_ctrl_t;

endpackage

// File: hdl/ks_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_cell: one compare cell of the sorting chain
// Holds one record. On load it keeps its record, takes its left neighbor's
// or takes the new record. On shift it takes its right neighbor's record.
// ----------------------------------------------------------------------------
module ks_cell #(
	parameter int PAYLOAD_BITS = ks_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ks_pkg::ks_ctrl_t             ctrl,
	input  logic [ks_pkg::KEY_BITS-1:0]  new_key,
	input  logic [PAYLOAD_BITS-1:0]      new_payload,
	input  logic                         prev_gt,
	input  logic                         prev_valid,
	input  logic [ks_pkg::KEY_BITS-1:0]  prev_key,
	input  logic [PAYLOAD_BITS-1:0]      prev_payload,
	input  logic                         next_valid,
	input  logic [ks_pkg::KEY_BITS-1:0]  next_key,
	input  logic [PAYLOAD_BITS-1:0]      next_payload,
	output logic                         gt,
	output logic                         valid,
	output logic [ks_pkg::KEY_BITS-1:0]  cell_key,
	output logic [PAYLOAD_BITS-1:0]      cell_payload
);

	logic                        valid_q;
	logic [ks_pkg::KEY_BITS-1:0] key_q;
	logic [PAYLOAD_BITS-1:0]     payload_q;

	// empty cells count as greater, so the chain reads 0..0 1..1
	assign gt = !valid_q || (key_q > new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load && gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && gt) begin
			key_q     <= prev_gt ? prev_key : new_key;
			payload_q <= prev_gt ? prev_payload : new_payload;
		end else if (ctrl.shift) begin
			key_q     <= next_key;
			payload_q <= next_payload;
		end
	end

	assign valid        = valid_q;
	assign cell_key     = key_q;
	assign cell_payload = payload_q;

endmodule

// File: hdl/keyed_record_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_sorter: batch sorter on a chain of compare cells
//
//   channel   valid      stall      fields
//   records   rec_valid  rec_stall  key, payload, batch_end
//   results   res_valid  res_stall  sorted_key, sorted_payload,
//                                   final_record, overflow
//
// Collecting: one record a cycle, each written straight into the cell chain.
// Draining: one result a cycle from the head cell while res_stall is low;
// rec_stall is high for the whole drain.
// A batch of N records gives min(N, MAX_ITEMS) results.
// res_stall freezes the chain while draining; reset empties every cell.
// ----------------------------------------------------------------------------
module keyed_record_sorter #(
	parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
	parameter int PAYLOAD_BITS = ks_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rec_valid,
	output logic                         rec_stall,
	input  logic [ks_pkg::KEY_BITS-1:0]  key,
	input  logic [PAYLOAD_BITS-1:0]      payload,
	input  logic                         batch_end,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [ks_pkg::KEY_BITS-1:0]  sorted_key,
	output logic [PAYLOAD_BITS-1:0]      sorted_payload,
	output logic                         final_record,
	output logic                         overflow
);

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   dropped_q;

	logic                        gt_w      [MAX_ITEMS];
	logic                        valid_w   [MAX_ITEMS+1];
	logic [ks_pkg::KEY_BITS-1:0] key_w     [MAX_ITEMS+1];
	logic [PAYLOAD_BITS-1:0]     payload_w [MAX_ITEMS+1];

	ks_pkg::ks_ctrl_t ctrl;
	logic             rec_beat;
	logic             res_beat;
	logic             full;

	assign full      = valid_w[MAX_ITEMS-1];
	assign rec_stall = (state_q == ST_DRAIN);
	assign rec_beat  = rec_valid && !rec_stall;
	assign res_valid = (state_q == ST_DRAIN) && valid_w[0];
	assign res_beat  = res_valid && !res_stall;

	assign ctrl.load  = rec_beat && !full;
	assign ctrl.shift = res_beat;

	// tail beyond the last cell reads as empty
	assign valid_w[MAX_ITEMS]   = 1'b0;
	assign key_w[MAX_ITEMS]     = '0;
	assign payload_w[MAX_ITEMS] = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		if (i == 0) begin : g_head
			ks_cell #(
				.PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.new_key      (key),
				.new_payload  (payload),
				.prev_gt      (1'b0),
				.prev_valid   (1'b0),
				.prev_key     ('0),
				.prev_payload ('0),
				.next_valid   (valid_w[1]),
				.next_key     (key_w[1]),
				.next_payload (payload_w[1]),
				.gt           (gt_w[0]),
				.valid        (valid_w[0]),
				.cell_key     (key_w[0]),
				.cell_payload (payload_w[0])
			);
		end else begin : g_body
			ks_cell #(
				.PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.new_key      (key),
				.new_payload  (payload),
				.prev_gt      (gt_w[i-1]),
				.prev_valid   (valid_w[i-1]),
				.prev_key     (key_w[i-1]),
				.prev_payload (payload_w[i-1]),
				.next_valid   (valid_w[i+1]),
				.next_key     (key_w[i+1]),
				.next_payload (payload_w[i+1]),
				.gt           (gt_w[i]),
				.valid        (valid_w[i]),
				.cell_key     (key_w[i]),
				.cell_payload (payload_w[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (rec_beat) begin
						if (full) begin
							dropped_q <= 1'b1;
						end
						if (batch_end) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (res_beat && !valid_w[1]) begin
						state_q   <= ST_COLLECT;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign sorted_key     = key_w[0];
	assign sorted_payload = payload_w[0];
	assign final_record   = !valid_w[1];
	assign overflow       = dropped_q;

endmodule

// File: sim/sort_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_order_checker: result checker for the keyed record sorter
// Watches both channels. Every accepted record beat goes into a shadow copy
// of the cell chain. Equal keys keep their arrival order, and records past
// capacity are dropped and flagged. A beat with batch_end queues the sorted
// batch as due results. Each result beat is compared field by field with the
// oldest due result.
// ----------------------------------------------------------------------------
module sort_order_checker #(
	parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
	parameter int PAYLOAD_BITS = ks_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rec_valid,
	input  logic                         rec_stall,
	input  logic [ks_pkg::KEY_BITS-1:0]  key,
	input  logic [PAYLOAD_BITS-1:0]      payload,
	input  logic                         batch_end,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  logic [ks_pkg::KEY_BITS-1:0]  sorted_key,
	input  logic [PAYLOAD_BITS-1:0]      sorted_payload,
	input  logic                         final_record,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           outstanding
);

	typedef struct packed {
		logic [ks_pkg::KEY_BITS-1:0] k;
		logic [PAYLOAD_BITS-1:0]     p;
		logic                        fin;
		logic                        ovf;
	} sorted_rec_t;

	logic [ks_pkg::KEY_BITS-1:0] chain_key [MAX_ITEMS];
	logic [PAYLOAD_BITS-1:0]     chain_pay [MAX_ITEMS];
	int                          chain_n;
	logic                        dropped;
	sorted_rec_t                 due_q[$];
	int                          errs;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		errs        = 0;
		chain_n     = 0;
		dropped     = 1'b0;
	end

	task automatic absorb_record(input logic [ks_pkg::KEY_BITS-1:0] k,
			input logic [PAYLOAD_BITS-1:0] p, input logic last);
		int pos;
		int i;
		sorted_rec_t r;
		if (chain_n < MAX_ITEMS) begin
			pos = chain_n;
			while (pos > 0 && chain_key[pos-1] > k) begin
				chain_key[pos] = chain_key[pos-1];
				chain_pay[pos] = chain_pay[pos-1];
				pos--;
			end
			chain_key[pos] = k;
			chain_pay[pos] = p;
			chain_n++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			for (i = 0; i < chain_n; i++) begin
				r.k   = chain_key[i];
				r.p   = chain_pay[i];
				r.fin = (i == chain_n - 1);
				r.ovf = dropped;
				due_q.push_back(r);
			end
			chain_n = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_result();
		sorted_rec_t want;
		if (due_q.size() == 0) begin
			$error("unexpected result beat: key %h payload %h", sorted_key, sorted_payload);
			errs++;
		end else begin
			want = due_q.pop_front();
			if (sorted_key !== want.k) begin
				$error("sorted_key: expected %h, got %h", want.k, sorted_key);
				errs++;
			end
			if (sorted_payload !== want.p) begin
				$error("sorted_payload: expected %h, got %h", want.p, sorted_payload);
				errs++;
			end
			if (final_record !== want.fin) begin
				$error("final_record: expected %b, got %b", want.fin, final_record);
				errs++;
			end
			if (overflow !== want.ovf) begin
				$error("overflow: expected %b, got %b", want.ovf, overflow);
				errs++;
			end
		end
	endtask

	// results first: a batch_end beat never has its own results in the same cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_n = 0;
			dropped = 1'b0;
			due_q.delete();
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall)
				check_result();
			if (rec_valid && !rec_stall)
				absorb_record(key, payload, batch_end);
			outstanding <= due_q.size();
			fail_count  <= errs;
		end
	end

endmodule

// File: sim/keyed_record_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_sorter_tb: top-level testbench for the keyed record sorter
// Sends a few hand-picked batches first: extreme keys and payloads, reverse
// order, ties, already sorted order and alternating bit patterns. The random
// batches that follow use wide and narrow key ranges, and some of them fill
// the store exactly or overflow it. Both channels idle at random, apart from
// one calm stretch. The checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module keyed_record_sorter_tb;

	localparam int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF;
	localparam int PAYLOAD_BITS = ks_pkg::PAYLOAD_BITS_DEF;
	localparam int KB           = ks_pkg::KEY_BITS;
	localparam int RANDOM_BEATS = 150;
	localparam int CYCLE_LIMIT  = 200000;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    rec_valid      = 1'b0;
	logic                    rec_stall;
	logic [KB-1:0]           key            = '0;
	logic [PAYLOAD_BITS-1:0] payload        = '0;
	logic                    batch_end      = 1'b0;
	logic                    res_valid;
	logic                    res_stall      = 1'b0;
	logic [KB-1:0]           sorted_key;
	logic [PAYLOAD_BITS-1:0] sorted_payload;
	logic                    final_record;
	logic                    overflow;
	logic                    calm           = 1'b0;
	int                      fail_count;
	int                      outstanding;
	int                      cycles         = 0;

	always #1 clk = ~clk;

	keyed_record_sorter #(
		.MAX_ITEMS    (MAX_ITEMS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec_stall      (rec_stall),
		.key            (key),
		.payload        (payload),
		.batch_end      (batch_end),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.sorted_key     (sorted_key),
		.sorted_payload (sorted_payload),
		.final_record   (final_record),
		.overflow       (overflow)
	);

	sort_order_checker #(
		.MAX_ITEMS    (MAX_ITEMS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (rec_valid),
		.rec_stall      (rec_stall),
		.key            (key),
		.payload        (payload),
		.batch_end      (batch_end),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.sorted_key     (sorted_key),
		.sorted_payload (sorted_payload),
		.final_record   (final_record),
		.overflow       (overflow),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	always @(posedge clk) begin
		res_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL keyed_record_sorter");
			$finish;
		end
	end

	// one record beat; valid stays up while stalled
	task automatic offer_record(input logic [KB-1:0] k, input logic [PAYLOAD_BITS-1:0] p,
			input logic last);
		while (!calm && $urandom_range(99) < 19) begin
			rec_valid <= 1'b0;
			@(posedge clk);
		end
		rec_valid <= 1'b1;
		key       <= k;
		payload   <= p;
		batch_end <= last;
		do @(posedge clk); while (rec_stall);
	endtask

	task automatic wait_drained();
		rec_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [KB-1:0] pick_key();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom_range(7);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int sent;
		int batch;
		int len;
		int i;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-record batches at the key and payload extremes
		offer_record('1, '0, 1'b1);
		offer_record('0, '1, 1'b1);
		// reverse order
		offer_record('1, 32'd1, 1'b0);
		offer_record(32'h8000_0000, 32'd2, 1'b0);
		offer_record(32'd5, 32'd3, 1'b0);
		offer_record('0, 32'd4, 1'b1);
		// ties keep arrival order
		offer_record(32'd7, 32'd10, 1'b0);
		offer_record(32'd3, 32'd11, 1'b0);
		offer_record(32'd7, 32'd12, 1'b0);
		offer_record(32'd3, 32'd13, 1'b0);
		offer_record(32'd7, 32'd14, 1'b1);
		// already sorted
		offer_record(32'd0, 32'hFFFF_0000, 1'b0);
		offer_record(32'd1, 32'h0000_FFFF, 1'b0);
		offer_record(32'd2, 32'h1234_5678, 1'b1);
		// alternating bit patterns
		offer_record(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		offer_record(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		wait_drained();

		// random batches; one exactly full, one overflowing (its batch_end record is dropped but still ends the batch)
		sent  = 0;
		batch = 0;
		while (sent < RANDOM_BEATS) begin
			calm <= (batch >= 3 && batch <= 5);
			case (batch)
				2:       len = MAX_ITEMS;
				5:       len = MAX_ITEMS + 2;
				default: len = $urandom_range(1, 10);
			endcase
			for (i = 0; i < len; i++)
				offer_record(pick_key(), pick_payload(), i == len - 1);
			sent += len;
			batch++;
		end
		calm <= 1'b0;

		wait_drained();
		repeat (MAX_ITEMS + 16) @(posedge clk);
		if (fail_count == 0)
			$display("PASS keyed_record_sorter");
		else
			$display("FAIL keyed_record_sorter");
		$finish;
	end

endmodule
